>>> hdl/wppl_pkg.sv
// ----------------------------------------------------------------------------
// wppl_pkg
// Shared widths, constants and types for the windowed peak-to-peak meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wppl_pkg;

  // Default ADC code width
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths
  localparam int LEVEL_BITS = 12;   // quiet/loud levels, peak_to_peak field
  localparam int COUNT_BITS = 8;    // window length and sample counter
  localparam int PCT_BITS   = 7;    // loudness percent, divider quotient
  // 200*excess + denom with excess < denom <= 4095 stays below 2^20
  localparam int NUM_BITS   = 20;

  localparam logic [PCT_BITS-1:0] PCT_ZERO = 7'd0;
  localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

  // Configuration register indexes
  localparam logic [1:0] REG_QUIET  = 2'd0;
  localparam logic [1:0] REG_LOUD   = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  // Register reset values
  localparam logic [LEVEL_BITS-1:0] QUIET_RST  = 12'd0;
  localparam logic [LEVEL_BITS-1:0] LOUD_RST   = 12'd248;
  localparam logic [COUNT_BITS-1:0] WINDOW_RST = 8'd40;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> hdl/wppl_divider.sv
// ----------------------------------------------------------------------------
// wppl_divider
// Restoring divider, one quotient bit per cycle through a single
// compare-and-subtract unit. Quotient is known to fit Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wppl_divider
  import wppl_pkg::*;
#(
  parameter int NUM_W = NUM_BITS,
  parameter int DEN_W = LEVEL_BITS,
  parameter int Q_W   = PCT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [DEN_W-1:0] denom,   // divides by 2*denom
  output div_status_t           status,
  output logic      [Q_W-1:0]   quotient
);

  localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              fits;

  // Shared compare unit
  assign fits = (rem >= divisor);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(Q_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Datapath: start with 2*denom aligned to the top quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= numer;
      divisor  <= NUM_W'({denom, 1'b0}) << (Q_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - divisor;
      end
      divisor  <= divisor >> 1;
      quotient <= {quotient[Q_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

>>> hdl/windowed_peak_to_peak_level.sv
// ----------------------------------------------------------------------------
// windowed_peak_to_peak_level
// Tracks window min/max over window_length samples, then reports the
// peak-to-peak value and a rounded, clamped loudness percent.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, sample                | in
//  out     | out_valid, out_ready, peak_to_peak,       | out
//          | loudness_percent                          |
//  cfg     | cfg_write, cfg_index, cfg_data            | in
//
//  A sample that does not close a window leaves the block ready. A closing
//  sample passes scale step and result load when the percent clamps, and
//  when it is divided: scale step, 7 divider steps (one quotient bit each
//  through the shared compare-subtract unit), divider done, result load.
//  The output register holds a result while out_ready is low; a following
//  closing sample waits in the load state until that slot frees.
//  rst is synchronous: window cleared, registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_peak_to_peak_level
  import wppl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [LEVEL_BITS-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LEVEL_BITS-1:0]       peak_to_peak,
  output logic [PCT_BITS-1:0]         loudness_percent
);

  localparam int CMP_W = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;

  logic [LEVEL_BITS-1:0]  quiet_level;
  logic [LEVEL_BITS-1:0]  loud_level;
  logic [COUNT_BITS-1:0]  window_length;

  logic [SAMPLE_BITS-1:0] window_low;
  logic [SAMPLE_BITS-1:0] window_high;
  logic [COUNT_BITS-1:0]  window_count;
  logic [SAMPLE_BITS-1:0] low_next;
  logic [SAMPLE_BITS-1:0] high_next;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   closes;

  logic [SAMPLE_BITS-1:0] p2p;
  logic [PCT_BITS-1:0]    pct;
  logic                   accept;
  logic                   out_load;

  logic [CMP_W-1:0]       p2p_ext;
  logic [CMP_W-1:0]       quiet_ext;
  logic [CMP_W-1:0]       excess;
  logic [LEVEL_BITS-1:0]  denom;
  logic [LEVEL_BITS-1:0]  excess_lo;
  logic                   at_floor;
  logic                   at_full;
  logic [NUM_BITS-1:0]    numer;
  logic                   div_start;
  div_status_t            div_status;
  logic [PCT_BITS-1:0]    div_quot;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_level   <= QUIET_RST;
      loud_level    <= LOUD_RST;
      window_length <= WINDOW_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_QUIET:  quiet_level   <= cfg_data;
        REG_LOUD:   loud_level    <= cfg_data;
        REG_WINDOW: window_length <= cfg_data[COUNT_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // Window tracking
  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign low_next   = (sample < window_low)  ? sample : window_low;
  assign high_next  = (sample > window_high) ? sample : window_high;
  assign count_next = window_count + 1'b1;
  assign closes     = (count_next >= window_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low   <= '1;
      window_high  <= '0;
      window_count <= '0;
    end else if (accept) begin
      if (closes) begin
        window_low   <= '1;
        window_high  <= '0;
        window_count <= '0;
      end else begin
        window_low   <= low_next;
        window_high  <= high_next;
        window_count <= count_next;
      end
    end
  end

  // Latched span of the closed window (high >= low once a sample is in)
  always_ff @(posedge clk) begin
    if (accept && closes) begin
      p2p <= high_next - low_next;
    end
  end

  // Scaling: clamp cases and divider numerator 200*excess + denom
  assign denom     = (loud_level > quiet_level) ? (loud_level - quiet_level)
                                                : LEVEL_BITS'(1);
  assign p2p_ext   = CMP_W'(p2p);
  assign quiet_ext = CMP_W'(quiet_level);
  assign excess    = p2p_ext - quiet_ext;
  assign excess_lo = excess[LEVEL_BITS-1:0];
  assign at_floor  = (p2p_ext <= quiet_ext);
  assign at_full   = (excess >= CMP_W'(denom));
  // 200 = 128 + 64 + 8
  assign numer     = NUM_BITS'({excess_lo, 7'b0}) + NUM_BITS'({excess_lo, 6'b0})
                   + NUM_BITS'({excess_lo, 3'b0}) + NUM_BITS'(denom);
  assign div_start = (state == ST_SCALE) && !at_floor && !at_full;

  wppl_divider #(
    .NUM_W (NUM_BITS),
    .DEN_W (LEVEL_BITS),
    .Q_W   (PCT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (denom),
    .status   (div_status),
    .quotient (div_quot)
  );

  // Sequencer
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && closes) state_next = ST_SCALE;
      ST_SCALE: state_next = div_start ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_status.done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Percent holding register
  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      pct <= at_floor ? PCT_ZERO : PCT_FULL;
    end else if (state == ST_DIV && div_status.done) begin
      pct <= div_quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      peak_to_peak     <= p2p_ext[LEVEL_BITS-1:0];
      loudness_percent <= pct;
    end
  end

  // Checks
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (loudness_percent <= PCT_FULL))
    else $error("loudness percent above full scale");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_status.busy)
    else $error("divider busy while taking samples");

  a_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == ST_IDLE))
    else $error("result load did not present a transfer");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_status.busy || div_status.done))
    else $error("divider idle while sequencer waits on it");

endmodule

`default_nettype wire

>>> sim/tb_windowed_peak_to_peak_level.sv
// ----------------------------------------------------------------------------
// tb_windowed_peak_to_peak_level
// Self-checking bench for the windowed peak-to-peak level meter. A directed
// table covers the field extremes, rounding of halves, clamping and the odd
// register settings. Random phases follow, each with fresh register values.
// Every result transfer is compared against a typed row or an in-bench
// window/percent model. Both channels idle at random, and one phase holds the
// output off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_windowed_peak_to_peak_level
  import wppl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int TOTAL_ITEMS   = 1050;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;

  // Index with no register behind it; writes must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [LEVEL_BITS-1:0] p2p;
    logic [PCT_BITS-1:0]   pct;
  } level_rec_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [1:0]            idx;
    logic [LEVEL_BITS-1:0] value;
    bit                    typed;
    logic [LEVEL_BITS-1:0] p2p;
    logic [PCT_BITS-1:0]   pct;
  } dir_row_t;

  localparam int NUM_ROWS = 31;

  // Directed rows: typed results only where they are obvious
  dir_row_t directed_rows [NUM_ROWS] = '{
    // one-sample windows at the reset levels
    '{ROW_WRITE,  REG_WINDOW, 12'd1,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd0,    1'b1, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd4095, 1'b1, 12'd0,    7'd0},
    // full-scale swing clamps, half of loud gives 50
    '{ROW_WRITE,  REG_WINDOW, 12'd2,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd0,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd4095, 1'b1, 12'd4095, 7'd100},
    '{ROW_SAMPLE, REG_QUIET,  12'd100,  1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd224,  1'b1, 12'd124,  7'd50},
    // halves round up: 0.5 -> 1, 1.5 -> 2
    '{ROW_WRITE,  REG_LOUD,   12'd200,  1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd10,   1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd11,   1'b1, 12'd1,    7'd1},
    '{ROW_SAMPLE, REG_QUIET,  12'd3000, 1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd2997, 1'b1, 12'd3,    7'd2},
    // loud below quiet: denominator pinned at one
    '{ROW_WRITE,  REG_QUIET,  12'd100,  1'b0, 12'd0,    7'd0},
    '{ROW_WRITE,  REG_LOUD,   12'd50,   1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd0,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd100,  1'b1, 12'd100,  7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd0,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd101,  1'b1, 12'd101,  7'd100},
    // both levels at full scale: nothing exceeds quiet
    '{ROW_WRITE,  REG_QUIET,  12'd4095, 1'b0, 12'd0,    7'd0},
    '{ROW_WRITE,  REG_LOUD,   12'd4095, 1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd4095, 1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd0,    1'b1, 12'd4095, 7'd0},
    // zero window length closes on every sample
    '{ROW_WRITE,  REG_QUIET,  12'd0,    1'b0, 12'd0,    7'd0},
    '{ROW_WRITE,  REG_WINDOW, 12'd0,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd2048, 1'b1, 12'd0,    7'd0},
    // upper data bits of the window write are dropped; spare index ignored
    '{ROW_WRITE,  REG_WINDOW, 12'hF03,  1'b0, 12'd0,    7'd0},
    '{ROW_WRITE,  REG_SPARE,  12'h001,  1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd1,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd2,    1'b0, 12'd0,    7'd0},
    '{ROW_SAMPLE, REG_QUIET,  12'd4000, 1'b0, 12'd0,    7'd0}
  };

  // DUT signals
  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [1:0]                  cfg_index = '0;
  logic [LEVEL_BITS-1:0]       cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [SAMPLE_BITS_DEF-1:0]  sample    = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [LEVEL_BITS-1:0]       peak_to_peak;
  logic [PCT_BITS-1:0]         loudness_percent;

  windowed_peak_to_peak_level dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .peak_to_peak     (peak_to_peak),
    .loudness_percent (loudness_percent)
  );

  always #(CLK_HALF) clk = ~clk;

  // Meter model state and register copies
  logic [LEVEL_BITS-1:0] quiet_cfg;
  logic [LEVEL_BITS-1:0] loud_cfg;
  logic [COUNT_BITS-1:0] win_len_cfg;
  logic [LEVEL_BITS-1:0] win_low;
  logic [LEVEL_BITS-1:0] win_high;
  logic [COUNT_BITS-1:0] win_count;

  level_rec_t pending_levels [$];

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  tx_gaps     = 1'b0;
  bit  rx_stalls   = 1'b0;
  bit  hold_req    = 1'b0;
  int  hold_left   = 0;
  int  stall_left  = 0;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 4) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Rounded, clamped percent for one peak-to-peak value
  function automatic logic [PCT_BITS-1:0] percent_of(input logic [LEVEL_BITS-1:0] p2p);
    int denom;
    int excess;
    denom = (loud_cfg > quiet_cfg) ? int'(loud_cfg) - int'(quiet_cfg) : 1;
    if (p2p <= quiet_cfg) return PCT_ZERO;
    excess = int'(p2p) - int'(quiet_cfg);
    if (excess >= denom) return PCT_FULL;
    return PCT_BITS'((200 * excess + denom) / (2 * denom));
  endfunction

  // Fold one sample into the window; returns 1 when the window closes
  function automatic bit meter_step(input logic [SAMPLE_BITS_DEF-1:0] s,
                                    output level_rec_t rec);
    logic [LEVEL_BITS-1:0] p2p;
    rec = '{default: '0};
    if (s < win_low) win_low = s;
    if (s > win_high) win_high = s;
    win_count = win_count + 1'b1;
    if (win_count < win_len_cfg) return 1'b0;
    p2p = (win_high >= win_low) ? win_high - win_low : '0;
    rec.p2p = p2p;
    rec.pct = percent_of(p2p);
    win_low   = '1;
    win_high  = '0;
    win_count = '0;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [LEVEL_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_QUIET:  quiet_cfg   = data;
      REG_LOUD:   loud_cfg    = data;
      REG_WINDOW: win_len_cfg = data[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Wait out every pending result, then the block's own latency
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_write <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] s, input bit has_typed,
                             input level_rec_t typed);
    level_rec_t rec;
    bit         closes;
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    closes = meter_step(s, rec);
    if (closes) pending_levels.push_back(has_typed ? typed : rec);
    items_sent++;
    if (tx_gaps && $urandom_range(0, 1) == 1) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = pick_gap() - 1;
      out_ready <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    level_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: p2p %0d pct %0d", peak_to_peak, loudness_percent);
      end else begin
        want = pending_levels.pop_front();
        if (peak_to_peak !== want.p2p || loudness_percent !== want.pct) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: p2p %0d/%0d pct %0d/%0d (expected/actual)",
                     want.p2p, peak_to_peak, want.pct, loudness_percent);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("windowed_peak_to_peak_level: mismatch");
      $finish;
    end
  end

  // Stimulus
  initial begin
    level_rec_t            typed;
    logic [LEVEL_BITS-1:0] q;
    logic [LEVEL_BITS-1:0] l;
    logic [COUNT_BITS-1:0] w;
    int                    phase;
    int                    n_items;
    int                    base;
    int                    amp;
    int                    s;

    quiet_cfg   = QUIET_RST;
    loud_cfg    = LOUD_RST;
    win_len_cfg = WINDOW_RST;
    win_low     = '1;
    win_high    = '0;
    win_count   = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        cfg_write <= 1'b0;
        typed.p2p = directed_rows[i].p2p;
        typed.pct = directed_rows[i].pct;
        send_sample(directed_rows[i].value, directed_rows[i].typed, typed);
      end
    end

    // Random phases, each with its own register settings
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      phase++;

      case ($urandom_range(0, 9))
        0:       q = '0;
        1:       q = '1;
        default: q = LEVEL_BITS'($urandom_range(0, 400));
      endcase
      case ($urandom_range(0, 9))
        0:       l = '0;
        1:       l = '1;
        2:       l = LEVEL_BITS'($urandom_range(0, q));
        default: l = LEVEL_BITS'((int'(q) + $urandom_range(1, 600) > 4095) ? 4095 :
                                 int'(q) + $urandom_range(1, 600));
      endcase
      case ($urandom_range(0, 19))
        0:          w = '0;
        1:          w = '1;
        2, 3, 4:    w = COUNT_BITS'($urandom_range(9, 64));
        default:    w = COUNT_BITS'($urandom_range(1, 8));
      endcase
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);

      // Pressure phase: one-sample windows, no input gaps, output held off
      if (phase == 3) begin
        w       = 8'd1;
        tx_gaps = 1'b0;
      end

      write_reg(REG_QUIET, q);
      write_reg(REG_LOUD, l);
      write_reg(REG_WINDOW, {4'($urandom_range(0, 15)), w});
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, LEVEL_BITS'($urandom));
      cfg_write <= 1'b0;

      if (phase == 3) hold_req = 1'b1;

      n_items = (w > 8'd64) ? 300 : $urandom_range(10, 60);
      if (n_items > TOTAL_ITEMS - items_sent) n_items = TOTAL_ITEMS - items_sent;
      // Swing sized around the loud level so percents spread over the range
      base = $urandom_range(0, 4095);
      amp  = (int'(l) + 64 > 4095) ? 4095 : $urandom_range(0, int'(l) + 64);
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 15)
          s = $urandom_range(0, 4095);
        else
          s = base + $urandom_range(0, amp);
        if (s > 4095) s = 4095;
        send_sample(SAMPLE_BITS_DEF'(s), 1'b0, typed);
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("windowed_peak_to_peak_level: match");
    end else begin
      $display("windowed_peak_to_peak_level: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/wppl_pkg.sv
hdl/wppl_divider.sv
hdl/windowed_peak_to_peak_level.sv
sim/tb_windowed_peak_to_peak_level.sv
